>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define NPGB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define NPGB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/npgb_pkg.sv
// ----------------------------------------------------------------------------
// Nearest point grid binning package
// Item types, memory entry layout, codes and fixed widths.
// ----------------------------------------------------------------------------
package npgb_pkg;

	// Fixed widths
	localparam int unsigned DIM_W       = 11;  // sensor dimension, up to 2047
	localparam int unsigned DS_W        = 4;   // downsample factor, up to 15
	localparam int unsigned RECIP_SH    = 24;  // reciprocal fraction bits
	localparam int unsigned RECIP_BITS  = 25;
	localparam int unsigned PROD_BITS   = 41;  // 16 bit value times reciprocal

	// Commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Result status codes
	localparam logic [2:0] STS_STORED     = 3'd0;
	localparam logic [2:0] STS_NOT_FINITE = 3'd1;
	localparam logic [2:0] STS_RANGE      = 3'd2;
	localparam logic [2:0] STS_GROUND     = 3'd3;
	localparam logic [2:0] STS_BEHIND     = 3'd4;
	localparam logic [2:0] STS_OFF_GRID   = 3'd5;
	localparam logic [2:0] STS_NOT_NEARER = 3'd6;

	// Register indexes
	localparam logic [2:0] REG_MIN_RANGE_SQ  = 3'd0;
	localparam logic [2:0] REG_MAX_RANGE_SQ  = 3'd1;
	localparam logic [2:0] REG_MODE          = 3'd2;
	localparam logic [2:0] REG_GROUND_NX     = 3'd3;
	localparam logic [2:0] REG_GROUND_NY     = 3'd4;
	localparam logic [2:0] REG_GROUND_NZ     = 3'd5;
	localparam logic [2:0] REG_GROUND_OFFSET = 3'd6;
	localparam logic [2:0] REG_GROUND_Z_MIN  = 3'd7;

	// Mode bits
	localparam int unsigned MODE_GROUND_BIT    = 0;
	localparam int unsigned MODE_TRANSPOSE_BIT = 1;

	// Input item
	typedef struct packed {
		logic               cmd;
		logic [15:0]        point_index;
		logic               finite;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [13:0]        cell_index;
	} cmd_item_t;

	// Result item
	typedef struct packed {
		logic [2:0]         status;
		logic               cell_valid;
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic signed [15:0] cell_z;
		logic [31:0]        cell_range_sq;
	} rsp_item_t;

	// One grid cell in memory
	typedef struct packed {
		logic               valid;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [31:0]        dist_sq;
	} cell_entry_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_SUM,
		S_DIV1_REM,
		S_DIV1_FIX,
		S_DIV2,
		S_DIV2_FIX,
		S_CELL,
		S_ADDR,
		S_LOOKUP,
		S_MEM
	} state_t;

endpackage

>>> rtl/nearest_point_grid_binning_top.sv
// ----------------------------------------------------------------------------
// Nearest point grid binning
// Filters depth camera points and keeps the nearest one per downsampled cell.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// cmd      in   cmd_valid/cmd_stall  cmd_item (insert a point or read a cell)
// rsp      out  rsp_valid/rsp_stall  rsp_item (one result per item)
// cfg      in   cfg_wr_en            cfg_index, cfg_data
//
// A read item goes from acceptance through the lookup and memory steps back
// to idle; an insert first steps through squares and the two constant divides
// for the cell mapping, then one memory read and, if the cell changes, one
// write back. After reset a clearing pass writes every cell once (9632 cells at
// the default sizes) while cmd_stall stays high; cfg writes are taken.
// A result waits in the output register under rsp_stall while the next item
// is accepted; the sequencer holds in its last step only if that item's
// result is ready before the waiting one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_point_grid_binning_top
	import npgb_pkg::*;
#(
	parameter int unsigned SENSOR_W   = 224,
	parameter int unsigned SENSOR_H   = 172,
	parameter int unsigned DOWNSAMPLE = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd_item,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_item_t   rsp_item,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Grid geometry
	localparam int unsigned GRID_W  = (SENSOR_W + DOWNSAMPLE - 1) / DOWNSAMPLE;
	localparam int unsigned GRID_H  = (SENSOR_H + DOWNSAMPLE - 1) / DOWNSAMPLE;
	localparam int unsigned GRID_N  = GRID_W * GRID_H;
	localparam int unsigned CELL_AW = (GRID_N > 1) ? $clog2(GRID_N) : 1;
	localparam int unsigned ENTRY_W = $bits(cell_entry_t);

	localparam logic [CELL_AW-1:0] CLR_LAST  = CELL_AW'(GRID_N - 1);
	localparam logic [15:0]        GRID_W_M1 = 16'(GRID_W - 1);
	localparam logic [15:0]        GRID_H_M1 = 16'(GRID_H - 1);

	// Divisors and their truncated reciprocals
	localparam logic [DIM_W-1:0]      DIV_W    = DIM_W'(SENSOR_W);
	localparam logic [DIM_W-1:0]      DIV_H    = DIM_W'(SENSOR_H);
	localparam logic [DS_W-1:0]       DIV_DS   = DS_W'(DOWNSAMPLE);
	localparam logic [RECIP_BITS-1:0] RECIP_W  = RECIP_BITS'((1 << RECIP_SH) / SENSOR_W);
	localparam logic [RECIP_BITS-1:0] RECIP_H  = RECIP_BITS'((1 << RECIP_SH) / SENSOR_H);
	localparam logic [RECIP_BITS-1:0] RECIP_DS =
		RECIP_BITS'((1 << RECIP_SH) / DOWNSAMPLE);

	// Configuration registers
	logic [31:0]        min_range_sq_q;
	logic [31:0]        max_range_sq_q;
	logic [1:0]         mode_q;
	logic signed [15:0] ground_nx_q;
	logic signed [15:0] ground_ny_q;
	logic signed [15:0] ground_nz_q;
	logic signed [15:0] ground_offset_q;
	logic signed [15:0] ground_z_min_q;

	// Control
	state_t             state_q, state_d;
	logic [CELL_AW-1:0] clr_cnt_q;
	logic               cmd_accept;
	logic               rsp_free;
	logic               rsp_load;
	logic               rsp_valid_q;
	rsp_item_t          rsp_item_q;
	rsp_item_t          rsp_next;

	// Captured item
	logic               cmd_q;
	logic [15:0]        idx_q;
	logic               fin_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic               cell_ok_q;

	// Arithmetic steps
	logic signed [31:0]  sq_x, sq_y, sq_z, dot_x, dot_y, dot_z;
	logic [31:0]         sq_x_q, sq_y_q, sq_z_q;
	logic signed [31:0]  dot_x_q, dot_y_q, dot_z_q;
	logic [PROD_BITS-1:0] prod1, prod1_q;
	logic [31:0]         range_q;
	logic signed [33:0]  dot_q;
	logic signed [33:0]  ground_lim_q;
	logic signed [16:0]  lim_diff;
	logic [15:0]         q1_est_q, q1_q;
	logic [26:0]         qd1;
	logic [15:0]         rem1_est_q;
	logic [DIM_W-1:0]    rem1_q;
	logic [DIM_W-1:0]    div1;
	logic [RECIP_BITS-1:0] recip1;
	logic [PROD_BITS-1:0] prod_a, prod_b, prod_a_q, prod_b_q;
	logic [15:0]         qa_est, qb_est, qa_d, qb_d, qa_q, qb_q;
	logic [19:0]         qa_ds, qb_ds;
	logic [2:0]          status_q, status_pre;
	logic                ongrid;
	logic [15:0]         col_d, row_d;
	logic [CELL_AW-1:0]  col_q, row_q;
	logic [CELL_AW-1:0]  cell_addr_q;

	// Cell memory
	logic [ENTRY_W-1:0]  cell_mem [GRID_N];
	cell_entry_t         rd_data_q;
	logic                rd_en;
	logic                mem_we;
	logic [CELL_AW-1:0]  mem_waddr;
	cell_entry_t         mem_wdata;
	logic                wr_cell;
	cell_entry_t         cell_wdata;

	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp_item   = rsp_item_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_sq_q  <= 32'd0;
			max_range_sq_q  <= 32'hC000_0000;
			mode_q          <= 2'd0;
			ground_nx_q     <= 16'sd0;
			ground_ny_q     <= 16'sd0;
			ground_nz_q     <= 16'sd16384;
			ground_offset_q <= 16'sd0;
			ground_z_min_q  <= 16'sh8000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_RANGE_SQ:  min_range_sq_q  <= cfg_data;
				REG_MAX_RANGE_SQ:  max_range_sq_q  <= cfg_data;
				REG_MODE:          mode_q          <= cfg_data[1:0];
				REG_GROUND_NX:     ground_nx_q     <= cfg_data[15:0];
				REG_GROUND_NY:     ground_ny_q     <= cfg_data[15:0];
				REG_GROUND_NZ:     ground_nz_q     <= cfg_data[15:0];
				REG_GROUND_OFFSET: ground_offset_q <= cfg_data[15:0];
				REG_GROUND_Z_MIN:  ground_z_min_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (clr_cnt_q == CLR_LAST) state_d = S_IDLE;
			S_IDLE: begin
				if (cmd_accept) begin
					state_d = (cmd_item.cmd == CMD_READ) ? S_LOOKUP : S_MUL;
				end
			end
			S_MUL:      state_d = S_SUM;
			S_SUM:      state_d = S_DIV1_REM;
			S_DIV1_REM: state_d = S_DIV1_FIX;
			S_DIV1_FIX: state_d = S_DIV2;
			S_DIV2:     state_d = S_DIV2_FIX;
			S_DIV2_FIX: state_d = S_CELL;
			S_CELL:     state_d = S_ADDR;
			S_ADDR:     state_d = S_LOOKUP;
			S_LOOKUP:   state_d = S_MEM;
			S_MEM:      if (rsp_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		cmd_stall = (state_q != S_IDLE);
		rd_en     = (state_q == S_LOOKUP);
		rsp_load  = (state_q == S_MEM) && rsp_free;
		mem_we    = 1'b0;
		mem_waddr = cell_addr_q;
		mem_wdata = cell_wdata;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (rsp_load) begin
			mem_we    = wr_cell;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Products for range, ground height and the first index divide
	always_comb begin
		sq_x   = x_q * x_q;
		sq_y   = y_q * y_q;
		sq_z   = z_q * z_q;
		dot_x  = ground_nx_q * x_q;
		dot_y  = ground_ny_q * y_q;
		dot_z  = ground_nz_q * z_q;
		recip1 = mode_q[MODE_TRANSPOSE_BIT] ? RECIP_H : RECIP_W;
		div1   = mode_q[MODE_TRANSPOSE_BIT] ? DIV_H : DIV_W;
		prod1  = PROD_BITS'(idx_q) * PROD_BITS'(recip1);
		lim_diff = 17'(ground_z_min_q) - 17'(ground_offset_q);
	end

	// Reject checks in the order of precedence
	always_comb begin
		qd1 = 27'(q1_est_q) * 27'(div1);
		if (!fin_q) begin
			status_pre = STS_NOT_FINITE;
		end else if (range_q < min_range_sq_q || range_q > max_range_sq_q) begin
			status_pre = STS_RANGE;
		end else if (mode_q[MODE_GROUND_BIT] && (dot_q < ground_lim_q)) begin
			status_pre = STS_GROUND;
		end else if (x_q <= 16'sd0) begin
			status_pre = STS_BEHIND;
		end else begin
			status_pre = STS_STORED;
		end
	end

	// Divide by the downsample factor, one correction step
	always_comb begin
		prod_a = PROD_BITS'(q1_q) * PROD_BITS'(RECIP_DS);
		prod_b = PROD_BITS'(rem1_q) * PROD_BITS'(RECIP_DS);
		qa_est = prod_a_q[RECIP_SH +: 16];
		qb_est = prod_b_q[RECIP_SH +: 16];
		qa_ds  = 20'(qa_est) * 20'(DIV_DS);
		qb_ds  = 20'(qb_est) * 20'(DIV_DS);
		qa_d   = qa_est;
		qb_d   = qb_est;
		if ((q1_q - qa_ds[15:0]) >= 16'(DIV_DS)) qa_d = qa_est + 16'd1;
		if ((16'(rem1_q) - qb_ds[15:0]) >= 16'(DIV_DS)) qb_d = qb_est + 16'd1;
	end

	// Column and row from the two quotients
	always_comb begin
		if (mode_q[MODE_TRANSPOSE_BIT]) begin
			ongrid = (qa_q <= GRID_W_M1) && (qb_q <= GRID_H_M1);
			col_d  = qa_q;
			row_d  = qb_q;
		end else begin
			ongrid = (qa_q <= GRID_H_M1) && (qb_q <= GRID_W_M1);
			col_d  = GRID_W_M1 - qb_q;
			row_d  = GRID_H_M1 - qa_q;
		end
	end

	// Result and write-back entry
	always_comb begin
		rsp_next   = '0;
		wr_cell    = 1'b0;
		cell_wdata = '0;
		if (cmd_q == CMD_READ) begin
			if (cell_ok_q && rd_data_q.valid) begin
				rsp_next.cell_valid    = 1'b1;
				rsp_next.cell_x        = rd_data_q.x;
				rsp_next.cell_y        = rd_data_q.y;
				rsp_next.cell_z        = rd_data_q.z;
				rsp_next.cell_range_sq = rd_data_q.dist_sq;
			end
			wr_cell = cell_ok_q;
		end else if (status_q != STS_STORED) begin
			rsp_next.status = status_q;
		end else if (rd_data_q.valid && !(range_q < rd_data_q.dist_sq)) begin
			rsp_next.status = STS_NOT_NEARER;
		end else begin
			rsp_next.status     = STS_STORED;
			wr_cell             = 1'b1;
			cell_wdata.valid    = 1'b1;
			cell_wdata.x        = x_q;
			cell_wdata.y        = y_q;
			cell_wdata.z        = z_q;
			cell_wdata.dist_sq  = range_q;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_accept) begin
					cmd_q       <= cmd_item.cmd;
					idx_q       <= cmd_item.point_index;
					fin_q       <= cmd_item.finite;
					x_q         <= cmd_item.pos_x;
					y_q         <= cmd_item.pos_y;
					z_q         <= cmd_item.pos_z;
					cell_ok_q   <= (32'(cmd_item.cell_index) < GRID_N);
					cell_addr_q <= CELL_AW'(cmd_item.cell_index);
				end
			end
			S_MUL: begin
				sq_x_q  <= sq_x;
				sq_y_q  <= sq_y;
				sq_z_q  <= sq_z;
				dot_x_q <= dot_x;
				dot_y_q <= dot_y;
				dot_z_q <= dot_z;
				prod1_q <= prod1;
			end
			S_SUM: begin
				range_q      <= sq_x_q + sq_y_q + sq_z_q;
				dot_q        <= 34'(dot_x_q) + 34'(dot_y_q) + 34'(dot_z_q);
				ground_lim_q <= {{3{lim_diff[16]}}, lim_diff, 14'd0};
				q1_est_q     <= prod1_q[RECIP_SH +: 16];
			end
			S_DIV1_REM: begin
				status_q   <= status_pre;
				rem1_est_q <= idx_q - qd1[15:0];
			end
			S_DIV1_FIX: begin
				if (rem1_est_q >= 16'(div1)) begin
					q1_q   <= q1_est_q + 16'd1;
					rem1_q <= DIM_W'(rem1_est_q - 16'(div1));
				end else begin
					q1_q   <= q1_est_q;
					rem1_q <= DIM_W'(rem1_est_q);
				end
			end
			S_DIV2: begin
				prod_a_q <= prod_a;
				prod_b_q <= prod_b;
			end
			S_DIV2_FIX: begin
				qa_q <= qa_d;
				qb_q <= qb_d;
			end
			S_CELL: begin
				col_q <= CELL_AW'(col_d);
				row_q <= CELL_AW'(row_d);
				if (status_q == STS_STORED && !ongrid) status_q <= STS_OFF_GRID;
			end
			S_ADDR: begin
				cell_addr_q <= CELL_AW'(32'(row_q) * GRID_W + 32'(col_q));
			end
			default: ;
		endcase
		if (rsp_load) rsp_item_q <= rsp_next;
	end

	// Cell memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
		if (rd_en) rd_data_q <= cell_mem[cell_addr_q];
	end

	// Checks
	`NPGB_ASSERT_NXT(a_busy_after_accept, cmd_accept, state_q != S_IDLE,
		"sequencer still idle after an accepted item")
	`NPGB_ASSERT_IMP(a_no_rsp_overwrite, rsp_load, !rsp_valid_q || !rsp_stall,
		"result register loaded over a waiting result")
	`NPGB_ASSERT_IMP(a_mem_after_lookup, state_q == S_MEM,
		$past(state_q) == S_LOOKUP || $past(state_q) == S_MEM,
		"cell result formed without a memory read")
	`NPGB_ASSERT_IMP(a_store_writes,
		rsp_load && cmd_q == CMD_INSERT && rsp_next.status == STS_STORED,
		mem_we && mem_wdata.valid,
		"stored status without a valid cell write")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Nearest point grid binning testbench
// Streams insert and read items through the block under randomized
// handshake pressure. A scoreboard keeps its own copy of the grid and the
// filter registers, predicts every result and checks the results in order.
// ----------------------------------------------------------------------------
module tb
	import npgb_pkg::*;
;

	localparam int SENSOR_W   = 224;
	localparam int SENSOR_H   = 172;
	localparam int DOWNSAMPLE = 2;
	localparam int GRID_W     = (SENSOR_W + DOWNSAMPLE - 1) / DOWNSAMPLE;
	localparam int GRID_H     = (SENSOR_H + DOWNSAMPLE - 1) / DOWNSAMPLE;
	localparam int GRID_N     = GRID_W * GRID_H;
	localparam int N_PIXELS   = SENSOR_W * SENSOR_H;
	localparam int N_PHASES   = 6;
	localparam int HOT_N      = 12;
	localparam int LONG_HOLD  = 400;

	// Register settings per phase, in register index order
	localparam logic [31:0] PHASE_REGS [N_PHASES][8] = '{
		'{32'd0, 32'hC000_0000, 32'd0, 32'd0, 32'd0, 32'h4000, 32'd0, 32'h8000},
		'{32'd250000, 32'd900000000, 32'd2, 32'd0, 32'd0, 32'h4000, 32'd0, 32'h8000},
		'{32'd0, 32'hC000_0000, 32'd1, 32'd0, 32'd0, 32'h4000, 32'd0, 32'hF830},
		'{32'd1, 32'h4000_0000, 32'd3, 32'hC000, 32'h4000, 32'hC000, 32'h7FFF, 32'h8000},
		'{32'hC000_0000, 32'hC000_0000, 32'd1, 32'h4000, 32'hC000, 32'd0, 32'h8000,
			32'h7FFF},
		'{32'd100, 32'hB2D0_5E00, 32'd0, 32'h1388, 32'hE4A8, 32'h3A98, 32'h04D2,
			32'hFE0C}
	};
	localparam int PHASE_ITEMS [N_PHASES] = '{200, 200, 200, 200, 60, 150};

	// Grid scoreboard: register copy, cell store and results in flight
	class grid_scoreboard;
		longint             min_r, max_r;
		logic [1:0]         mode;
		longint             nx, ny, nz, g_offset, z_min;
		bit                 held [GRID_N];
		logic signed [15:0] px [GRID_N];
		logic signed [15:0] py [GRID_N];
		logic signed [15:0] pz [GRID_N];
		logic [31:0]        pr [GRID_N];
		rsp_item_t          expected_q [$];
		int                 status_count [7];
		int                 n_inserts, n_reads, reads_full;
		int                 checked, mismatches, unexpected;

		function new();
			min_r    = 0;
			max_r    = 64'd3221225472;
			mode     = '0;
			nx       = 0;
			ny       = 0;
			nz       = 16384;
			g_offset = 0;
			z_min    = -32768;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_MIN_RANGE_SQ:  min_r = {32'd0, data};
				REG_MAX_RANGE_SQ:  max_r = {32'd0, data};
				REG_MODE:          mode = data[1:0];
				REG_GROUND_NX:     nx = $signed(data[15:0]);
				REG_GROUND_NY:     ny = $signed(data[15:0]);
				REG_GROUND_NZ:     nz = $signed(data[15:0]);
				REG_GROUND_OFFSET: g_offset = $signed(data[15:0]);
				default:           z_min = $signed(data[15:0]);
			endcase
		endfunction

		// Pixel index to grid cell, -1 when off the grid
		function int cell_of(int idx);
			int col, row;
			if (mode[MODE_TRANSPOSE_BIT]) begin
				col = (idx / SENSOR_H) / DOWNSAMPLE;
				row = (idx % SENSOR_H) / DOWNSAMPLE;
			end else begin
				col = GRID_W - 1 - (idx % SENSOR_W) / DOWNSAMPLE;
				row = GRID_H - 1 - (idx / SENSOR_W) / DOWNSAMPLE;
			end
			if (col < 0 || row < 0 || col >= GRID_W || row >= GRID_H)
				return -1;
			return row * GRID_W + col;
		endfunction

		// Filter chain, then nearest-point update of the cell
		function logic [2:0] bin_point(cmd_item_t it);
			longint x, y, z, r, dot, lim;
			int c;
			x = $signed(it.pos_x);
			y = $signed(it.pos_y);
			z = $signed(it.pos_z);
			r = x * x + y * y + z * z;
			if (!it.finite)
				return STS_NOT_FINITE;
			if (r < min_r || r > max_r)
				return STS_RANGE;
			if (mode[MODE_GROUND_BIT]) begin
				dot = nx * x + ny * y + nz * z;
				lim = (z_min - g_offset) * 16384;
				if (dot < lim)
					return STS_GROUND;
			end
			if (x <= 0)
				return STS_BEHIND;
			c = cell_of(int'(it.point_index));
			if (c < 0)
				return STS_OFF_GRID;
			if (held[c] && !(r < pr[c]))
				return STS_NOT_NEARER;
			held[c] = 1'b1;
			px[c]   = it.pos_x;
			py[c]   = it.pos_y;
			pz[c]   = it.pos_z;
			pr[c]   = 32'(r);
			return STS_STORED;
		endfunction

		function void note_item(cmd_item_t it);
			rsp_item_t e;
			int c;
			e = '0;
			if (it.cmd == CMD_INSERT) begin
				e.status = bin_point(it);
				status_count[e.status]++;
				n_inserts++;
			end else begin
				n_reads++;
				c = int'(it.cell_index);
				if (c < GRID_N && held[c]) begin
					e.cell_valid    = 1'b1;
					e.cell_x        = px[c];
					e.cell_y        = py[c];
					e.cell_z        = pz[c];
					e.cell_range_sq = pr[c];
					held[c]         = 1'b0;
					reads_full++;
				end
			end
			expected_q.push_back(e);
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t e;
			bit bad;
			checked++;
			if (expected_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("tb: result %0d arrived with nothing expected", checked);
				return;
			end
			e = expected_q.pop_front();
			bad = (got.status !== e.status) || (got.cell_valid !== e.cell_valid) ||
				(got.cell_x !== e.cell_x) || (got.cell_y !== e.cell_y) ||
				(got.cell_z !== e.cell_z) || (got.cell_range_sq !== e.cell_range_sq);
			if (bad) begin
				mismatches++;
				if (mismatches + unexpected <= 10) begin
					$display("tb: result %0d expected sts %0d vld %0d xyz %0d/%0d/%0d r %0d",
						checked, e.status, e.cell_valid, e.cell_x, e.cell_y, e.cell_z,
						e.cell_range_sq);
					$display("tb: result %0d got      sts %0d vld %0d xyz %0d/%0d/%0d r %0d",
						checked, got.status, got.cell_valid, got.cell_x, got.cell_y,
						got.cell_z, got.cell_range_sq);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cmd_valid   = 1'b0;
	logic        cmd_stall;
	cmd_item_t   cmd_item    = '0;
	logic        rsp_valid;
	logic        rsp_stall   = 1'b0;
	rsp_item_t   rsp_item;
	logic        cfg_wr_en   = 1'b0;
	logic [2:0]  cfg_index   = REG_MIN_RANGE_SQ;
	logic [31:0] cfg_data    = '0;

	grid_scoreboard sb = new();
	int             long_holds_asked = 0;
	int             burst_left = 0;
	int             hot_pool [HOT_N];

	nearest_point_grid_binning_top #(
		.SENSOR_W   (SENSOR_W),
		.SENSOR_H   (SENSOR_H),
		.DOWNSAMPLE (DOWNSAMPLE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	// Item builders; unused fields carry random bits
	function automatic cmd_item_t mk_insert(int idx, bit fin, int x, int y, int z);
		cmd_item_t it;
		it.cmd         = CMD_INSERT;
		it.point_index = idx[15:0];
		it.finite      = fin;
		it.pos_x       = x[15:0];
		it.pos_y       = y[15:0];
		it.pos_z       = z[15:0];
		it.cell_index  = 14'($urandom);
		return it;
	endfunction

	function automatic cmd_item_t mk_read(int c);
		cmd_item_t it;
		logic [95:0] raw;
		raw           = {$urandom, $urandom, $urandom};
		it            = raw[79:0];
		it.cmd        = CMD_READ;
		it.cell_index = c[13:0];
		return it;
	endfunction

	// A pixel at or next to one of the phase's hot spots
	function automatic int hot_pixel();
		int base, idx;
		base = hot_pool[$urandom_range(0, HOT_N - 1)];
		idx  = base + $urandom_range(0, 1) + SENSOR_W * $urandom_range(0, 1);
		return (idx < N_PIXELS) ? idx : base;
	endfunction

	function automatic int rand_coord();
		int span;
		case ($urandom_range(0, 2))
			0:       span = 1000;
			1:       span = 8000;
			default: span = 32767;
		endcase
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int rand_x();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(1, 1000);
			1:       return $urandom_range(1, 8000);
			2:       return $urandom_range(1, 32767);
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Mostly well-formed inserts on hot cells, reads of those cells, some noise
	function automatic cmd_item_t random_item();
		int sel, idx, c;
		cmd_item_t it;
		logic [95:0] raw;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			raw = {$urandom, $urandom, $urandom};
			it  = raw[79:0];
			return it;
		end
		if (sel < 72) begin
			idx = ($urandom_range(0, 9) < 7) ? hot_pixel() : $urandom_range(0, N_PIXELS - 1);
			return mk_insert(idx, $urandom_range(0, 19) != 0, rand_x(), rand_coord(),
				rand_coord());
		end
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			c = sb.cell_of(hot_pixel());
			if (c < 0)
				c = $urandom_range(0, GRID_N - 1);
		end else if (sel < 85) begin
			c = $urandom_range(0, GRID_N - 1);
		end else begin
			c = $urandom_range(0, 16383);
		end
		return mk_read(c);
	endfunction

	// Offer one item and hold it until accepted; bursts end in random gaps
	task automatic send_item(input cmd_item_t it);
		int gap;
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		sb.note_item(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering until every expected result is in
	task automatic drain(input int extra);
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Narrow registers get random upper bits, which the block must ignore
	function automatic logic [31:0] pad16(logic [31:0] v);
		return {16'($urandom), v[15:0]};
	endfunction

	task automatic program_phase(input int p);
		write_reg(REG_MIN_RANGE_SQ, PHASE_REGS[p][REG_MIN_RANGE_SQ]);
		write_reg(REG_MAX_RANGE_SQ, PHASE_REGS[p][REG_MAX_RANGE_SQ]);
		write_reg(REG_MODE, {30'($urandom), PHASE_REGS[p][REG_MODE][1:0]});
		write_reg(REG_GROUND_NX, pad16(PHASE_REGS[p][REG_GROUND_NX]));
		write_reg(REG_GROUND_NY, pad16(PHASE_REGS[p][REG_GROUND_NY]));
		write_reg(REG_GROUND_NZ, pad16(PHASE_REGS[p][REG_GROUND_NZ]));
		write_reg(REG_GROUND_OFFSET, pad16(PHASE_REGS[p][REG_GROUND_OFFSET]));
		write_reg(REG_GROUND_Z_MIN, pad16(PHASE_REGS[p][REG_GROUND_Z_MIN]));
		cfg_wr_en <= 1'b0;
	endtask

	// Boundary items for the settings of some phases
	task automatic run_directed(input int p);
		case (p)
			0: begin
				// non-finite, then corner cells, equal and farther points
				send_item(mk_insert(0, 1'b0, 100, 0, 0));
				send_item(mk_insert(0, 1'b1, 32767, -32768, -32768));
				send_item(mk_insert(SENSOR_W, 1'b1, -32768, -32768, -32768));
				send_item(mk_insert(5, 1'b1, 0, 5, 5));
				send_item(mk_insert(N_PIXELS - 1, 1'b1, 1, 0, 0));
				send_item(mk_insert(N_PIXELS - 1, 1'b1, 1, 0, 0));
				send_item(mk_insert(N_PIXELS - 2, 1'b1, 2, 0, 0));
				// pixel index past the frame
				send_item(mk_insert(N_PIXELS, 1'b1, 10, 0, 0));
				send_item(mk_insert(65535, 1'b1, 10, 0, 0));
				// nearer point replaces the one in the last cell
				send_item(mk_insert(1, 1'b1, 100, -3, 7));
				send_item(mk_read(GRID_N - 1));
				send_item(mk_read(GRID_N - 1));
				send_item(mk_read(0));
				// reads beyond the grid
				send_item(mk_read(GRID_N));
				send_item(mk_read(16383));
			end
			1: begin
				// range limits, just outside and exactly on
				send_item(mk_insert(100, 1'b1, 499, 0, 0));
				send_item(mk_insert(100, 1'b1, 500, 0, 0));
				send_item(mk_insert(300, 1'b1, 30000, 0, 0));
				send_item(mk_insert(300, 1'b1, 30001, 0, 0));
			end
			2: begin
				// height test, below and exactly on the limit
				send_item(mk_insert(1000, 1'b1, 100, 0, -2001));
				send_item(mk_insert(1000, 1'b1, 100, 0, -2000));
			end
			4: begin
				send_item(mk_insert(2000, 1'b1, -32768, -32768, -32768));
				send_item(mk_insert(2000, 1'b1, 32767, -32768, -32768));
			end
			default: ;
		endcase
	endtask

	// Receiver: checks accepted results, stalls in segments of its own
	initial begin : result_sink
		int seg_left   = 0;
		int seg_kind   = 0;
		int hold_left  = 0;
		int holds_done = 0;
		logic stall_next;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
				sb.check_result(rsp_item);
			if (hold_left == 0 && holds_done < long_holds_asked) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 60);
					seg_kind = $urandom_range(0, 3);
				end
				seg_left--;
				case (seg_kind)
					0:       stall_next = 1'b0;
					1:       stall_next = ($urandom_range(0, 3) == 0);
					2:       stall_next = ($urandom_range(0, 3) != 0);
					default: stall_next = ~rsp_stall;
				endcase
			end
			rsp_stall <= stall_next;
		end
	end

	// Main sequence
	initial begin : stimulus
		int failures;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0)
				drain(16);
			program_phase(p);
			foreach (hot_pool[h])
				hot_pool[h] = $urandom_range(0, N_PIXELS - 1);
			run_directed(p);
			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				// long receiver hold while items keep coming
				if (p == 1 && n == 40)
					long_holds_asked++;
				// sender waits out the pipeline once mid-phase
				if (p == 3 && n == 100)
					drain(0);
				send_item(random_item());
			end
		end
		drain(20);

		failures = sb.mismatches + sb.unexpected + sb.pending();
		$display("tb: %0d items (%0d inserts, %0d reads, %0d of full cells), %0d settings",
			sb.n_inserts + sb.n_reads, sb.n_inserts, sb.n_reads, sb.reads_full, N_PHASES);
		$display("tb: insert outcomes stored/nan/range/ground/behind/off/farther %0d/%0d/%0d/%0d/%0d/%0d/%0d",
			sb.status_count[0], sb.status_count[1], sb.status_count[2], sb.status_count[3],
			sb.status_count[4], sb.status_count[5], sb.status_count[6]);
		if (failures == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> nearest_point_grid_binning_top.f
+incdir+rtl
rtl/npgb_pkg.sv
rtl/nearest_point_grid_binning_top.sv
sim/tb.sv
